>>> design/sdib_pkg.sv
package sdib_pkg;

	// input action codes, action 3 behaves as a read
	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_READ   = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;
	localparam logic [1:0] ACT_SPARE  = 2'd3;

	// result status codes
	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_READ_OK  = 3'd2;
	localparam logic [2:0] ST_READ_OOR = 3'd3;
	localparam logic [2:0] ST_CLEARED  = 3'd4;

	localparam logic [3:0] RPB_RESET = 4'd5;

	localparam int KEY_W = 32;
	localparam int POS_W = 10;
	localparam int RIDX_W = 9;

	// collection tree: eight children per node
	localparam int FANIN_LOG = 3;
	localparam int FANIN = 1 << FANIN_LOG;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic              ins;
		logic              rd;
		logic [KEY_W-1:0]  key;
		logic [POS_W-1:0]  pos;
		logic [RIDX_W-1:0] ridx;
	} bcast_t;

	// nodes at tree level l (level 0 is the leaves)
	function automatic int level_nodes(input int n, input int l);
		int span;
		span = 1 << (FANIN_LOG * l);
		return (n + span - 1) >> (FANIN_LOG * l);
	endfunction

	// registered levels needed to reduce n leaves to one node
	function automatic int tree_levels(input int n);
		int l;
		l = 1;
		while (level_nodes(n, l) > 1) l++;
		return l;
	endfunction

	// first node of level l in the flat node array
	function automatic int level_base(input int n, input int l);
		int b;
		b = 0;
		for (int k = 1; k < l; k++) b += level_nodes(n, k);
		return b;
	endfunction

endpackage

>>> design/sdib_cell.sv
module sdib_cell #(
	parameter int INDEX = 0,
	parameter int CW = 10,
	parameter int IW = 9
) (
	input  logic                      clk,
	input  sdib_pkg::bcast_t          bc,
	input  logic [CW-1:0]             fill,
	input  logic                      prev_ge,
	input  logic [sdib_pkg::KEY_W-1:0] prev_key,
	input  logic [sdib_pkg::POS_W-1:0] prev_pos,
	output logic                      ge,
	output logic [sdib_pkg::KEY_W-1:0] key_q,
	output logic [sdib_pkg::POS_W-1:0] pos_q,
	output logic [IW+sdib_pkg::KEY_W+sdib_pkg::POS_W-1:0] leaf
);

	logic occ;
	logic bnd;
	logic hit;
	logic sel;

	// empty cells count as not smaller so the boundary lands at the fill point
	assign occ = CW'(INDEX) < fill;
	assign ge  = !occ || !($signed(key_q) < $signed(bc.key));
	assign bnd = ge && !prev_ge;
	assign hit = int'(bc.ridx) == INDEX;
	assign sel = (bc.ins && bnd) || (bc.rd && occ && hit);

	assign leaf = sel ? {IW'(INDEX), key_q, pos_q} : '0;

	always_ff @(posedge clk) begin
		if (bc.ins) begin
			if (prev_ge) begin
				key_q <= prev_key;
				pos_q <= prev_pos;
			end else if (ge) begin
				key_q <= bc.key;
				pos_q <= bc.pos;
			end
		end
	end

endmodule

>>> design/sdib_or_tree.sv
module sdib_or_tree #(
	parameter int N = 512,
	parameter int W = 51
) (
	input  logic         clk,
	input  logic         cap,
	input  logic [W-1:0] leaf [N],
	output logic [W-1:0] root
);

	localparam int LV = sdib_pkg::tree_levels(N);
	localparam int NT = sdib_pkg::level_base(N, LV + 1);
	localparam int L2 = sdib_pkg::level_nodes(N, 1);

	logic [W-1:0] node_q [NT];
	logic [W-1:0] nxt [NT];

	always_comb begin
		logic [W-1:0] acc;
		int c;
		for (int i = 0; i < NT; i++) nxt[i] = '0;
		for (int l = 1; l <= LV; l++) begin
			for (int j = 0; j < sdib_pkg::level_nodes(N, l); j++) begin
				acc = '0;
				for (int k = 0; k < sdib_pkg::FANIN; k++) begin
					c = (j << sdib_pkg::FANIN_LOG) + k;
					if (c < sdib_pkg::level_nodes(N, l - 1)) begin
						if (l == 1) acc = acc | leaf[c];
						else acc = acc | node_q[sdib_pkg::level_base(N, l - 1) + c];
					end
				end
				nxt[sdib_pkg::level_base(N, l) + j] = acc;
			end
		end
	end

	// first level samples the cells once per item, upper levels settle after
	always_ff @(posedge clk) begin
		for (int i = 0; i < NT; i++) begin
			if (i >= L2 || cap) node_q[i] <= nxt[i];
		end
	end

	assign root = node_q[NT-1];

endmodule

>>> design/sorted_dense_index_builder.sv
// Sorted dense index: a chain of TABLE_ENTRIES cells holds (key, record position)
// entries in ascending signed key order, cell i holding table index i. An insert
// word (tuser action 0) forms position = min(block_ordinal, BLOCK_COUNT-1) *
// records_per_block + slot_in_block, wrapped to 10 bits, and every cell compares
// its key with the new one in the same cycle: the entry lands before the first
// stored key that is not smaller, and each later cell takes its left neighbor's
// entry. A full table drops the insert with status 1. A read word (action 1 or 3)
// returns the entry at read_index, status 3 and zeros past the fill count; a
// clear word (action 2) empties the table. Every input word gives one output
// word. The chosen cell reports its index, key and position through a registered
// OR tree of fan-in eight. A new word is taken only once the last word's result
// is loaded into the output register, which waits while the output is stalled; a
// result can sit in the output register while the next word is taken. The user
// must write records_per_block through cfg_we / cfg_wdata only while no word is in
// flight, which the block does not enforce; reset leaves it at 5, table empty.
module sorted_dense_index_builder #(
	parameter int TABLE_ENTRIES = 512,
	parameter int BLOCK_COUNT = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: records_per_block
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	// input words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // record_key, block_ordinal, slot_in_block, read_index
	input  logic [1:0]  s_tuser,  // action
	// result words
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // placed_at, entry_count, entry_key, entry_position
	output logic [2:0]  m_tuser   // status
);

	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int KW = sdib_pkg::KEY_W;
	localparam int PW = sdib_pkg::POS_W;
	localparam int LW = IW + KW + PW;
	localparam int LV = sdib_pkg::tree_levels(TABLE_ENTRIES);
	localparam int WTW = $clog2(LV + 1);

	typedef enum logic {
		IDLE,
		COLLECT
	} state_t;

	state_t state_q;
	logic [WTW-1:0] wait_q;
	logic [3:0] rpb_q;
	logic [CW-1:0] fill_q;
	logic [2:0] status_q;

	// input word fields
	logic [1:0]  in_action;
	logic [31:0] in_key;
	logic [6:0]  in_ordinal;
	logic [2:0]  in_slot;
	logic [8:0]  in_ridx;

	logic accept;
	logic full;
	logic is_ins;
	logic is_rd;
	logic is_clr;

	logic [6:0]  ord_sat;
	logic [10:0] prod;
	logic [11:0] pos_sum;

	sdib_pkg::bcast_t bc;

	// chain wiring
	logic          ge_w   [TABLE_ENTRIES];
	logic [KW-1:0] key_w  [TABLE_ENTRIES];
	logic [PW-1:0] pos_w  [TABLE_ENTRIES];
	logic [LW-1:0] leaf_w [TABLE_ENTRIES];
	logic [LW-1:0] root;

	logic [IW-1:0] root_idx;
	logic [KW-1:0] root_key;
	logic [PW-1:0] root_pos;
	logic          out_free;
	logic          load_out;
	logic [63:0]   out_data;

	assign in_action  = s_tuser;
	assign in_key     = s_tdata[31:0];
	assign in_ordinal = s_tdata[38:32];
	assign in_slot    = s_tdata[41:39];
	assign in_ridx    = s_tdata[50:42];

	assign s_tready = state_q == IDLE;
	assign accept   = s_tvalid && s_tready;
	assign full     = fill_q == CW'(TABLE_ENTRIES);

	always_comb begin
		is_ins = 1'b0;
		is_rd  = 1'b0;
		is_clr = 1'b0;
		unique case (in_action)
			sdib_pkg::ACT_INSERT: is_ins = 1'b1;
			sdib_pkg::ACT_CLEAR:  is_clr = 1'b1;
			sdib_pkg::ACT_READ,
			sdib_pkg::ACT_SPARE:  is_rd  = 1'b1;
			default:              is_rd  = 1'b1;
		endcase
	end

	// record position from ordinal and blocking factor
	assign ord_sat = (int'(in_ordinal) > BLOCK_COUNT - 1) ? 7'(BLOCK_COUNT - 1) : in_ordinal;
	assign prod    = 11'(ord_sat) * 11'(rpb_q);
	assign pos_sum = 12'(prod) + 12'(in_slot);

	always_comb begin
		bc.ins  = accept && is_ins && !full;
		bc.rd   = accept && is_rd;
		bc.key  = in_key;
		bc.pos  = pos_sum[PW-1:0];
		bc.ridx = in_ridx;
	end

	// the cell chain
	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		if (i == 0) begin : g_head
			sdib_cell #(.INDEX(i), .CW(CW), .IW(IW)) u_cell (
				.clk      (clk),
				.bc       (bc),
				.fill     (fill_q),
				.prev_ge  (1'b0),
				.prev_key ('0),
				.prev_pos ('0),
				.ge       (ge_w[i]),
				.key_q    (key_w[i]),
				.pos_q    (pos_w[i]),
				.leaf     (leaf_w[i])
			);
		end else begin : g_body
			sdib_cell #(.INDEX(i), .CW(CW), .IW(IW)) u_cell (
				.clk      (clk),
				.bc       (bc),
				.fill     (fill_q),
				.prev_ge  (ge_w[i-1]),
				.prev_key (key_w[i-1]),
				.prev_pos (pos_w[i-1]),
				.ge       (ge_w[i]),
				.key_q    (key_w[i]),
				.pos_q    (pos_w[i]),
				.leaf     (leaf_w[i])
			);
		end
	end

	// gathers the one selected cell's index and entry
	sdib_or_tree #(.N(TABLE_ENTRIES), .W(LW)) u_tree (
		.clk  (clk),
		.cap  (accept),
		.leaf (leaf_w),
		.root (root)
	);

	assign root_idx = root[LW-1 -: IW];
	assign root_key = root[KW+PW-1 -: KW];
	assign root_pos = root[PW-1:0];

	assign out_free = !m_tvalid || m_tready;
	assign load_out = (state_q == COLLECT) && (wait_q == '0) && out_free;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpb_q <= sdib_pkg::RPB_RESET;
		end else if (cfg_we) begin
			rpb_q <= cfg_wdata;
		end
	end

	// sequencer: take a word, let the tree settle, hand the result over
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			wait_q   <= '0;
			fill_q   <= '0;
			status_q <= sdib_pkg::ST_INSERTED;
			m_tvalid <= 1'b0;
		end else begin
			m_tvalid <= load_out || (m_tvalid && !m_tready);
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						state_q <= COLLECT;
						wait_q  <= WTW'(LV - 1);
						priority if (is_clr) begin
							fill_q   <= '0;
							status_q <= sdib_pkg::ST_CLEARED;
						end else if (is_ins) begin
							if (full) begin
								status_q <= sdib_pkg::ST_FULL;
							end else begin
								fill_q   <= fill_q + CW'(1);
								status_q <= sdib_pkg::ST_INSERTED;
							end
						end else begin
							if (int'(in_ridx) < int'(fill_q)) status_q <= sdib_pkg::ST_READ_OK;
							else status_q <= sdib_pkg::ST_READ_OOR;
						end
					end
				end
				COLLECT: begin
					if (wait_q != '0) begin
						wait_q <= wait_q - WTW'(1);
					end else if (out_free) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	// result word fields, unused ones stay zero
	always_comb begin
		out_data = '0;
		out_data[18:9] = 10'(fill_q);
		if (status_q == sdib_pkg::ST_INSERTED) out_data[8:0] = 9'(root_idx);
		if (status_q == sdib_pkg::ST_READ_OK) begin
			out_data[50:19] = root_key;
			out_data[60:51] = root_pos;
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tuser <= status_q;
			m_tdata <= out_data;
		end
	end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	localparam int TABLE_ENTRIES = 512;
	localparam int BLOCK_COUNT = 128;

	// receiver stall patterns
	localparam int RX_OPEN = 0;
	localparam int RX_CHOPPY = 1;
	localparam int RX_BURSTY = 2;

	// one expected result word
	typedef struct packed {
		logic [2:0]  status;
		logic [8:0]  placed_at;
		logic [9:0]  entry_count;
		logic [31:0] entry_key;
		logic [9:0]  entry_position;
	} index_result_t;

	// shadow copy of the sorted table plus the queue of results still owed
	class dense_index_tracker;
		logic [31:0]   key_table[TABLE_ENTRIES];
		logic [9:0]    pos_table[TABLE_ENTRIES];
		int unsigned   fill;
		logic [3:0]    blocking;
		index_result_t awaited[$];
		int            errors;
		int            n_inserted, n_dropped, n_read_ok, n_read_oor, n_cleared, n_checked;

		function new();
			fill = 0;
			blocking = sdib_pkg::RPB_RESET;
			errors = 0;
			n_inserted = 0;
			n_dropped = 0;
			n_read_ok = 0;
			n_read_oor = 0;
			n_cleared = 0;
			n_checked = 0;
		endfunction

		function void set_blocking(input logic [3:0] value);
			blocking = value;
		endfunction

		// work out the result of one accepted input word and update the table
		function void note_word(input logic [1:0] act, input logic [31:0] key,
				input logic [6:0] ordinal, input logic [2:0] slot,
				input logic [8:0] ridx);
			index_result_t r;
			int unsigned   ord_sat, spot;
			logic [9:0]    pos;
			r = '0;
			if (act == sdib_pkg::ACT_INSERT) begin
				if (fill >= TABLE_ENTRIES) begin
					r.status = sdib_pkg::ST_FULL;
					n_dropped++;
				end else begin
					ord_sat = (ordinal >= BLOCK_COUNT) ? BLOCK_COUNT - 1 : ordinal;
					pos = 10'(ord_sat * blocking + slot);
					// first stored key that is not smaller than the new one
					spot = 0;
					while (spot < fill && $signed(key_table[spot]) < $signed(key))
						spot++;
					for (int n = fill; n > spot; n--) begin
						key_table[n] = key_table[n-1];
						pos_table[n] = pos_table[n-1];
					end
					key_table[spot] = key;
					pos_table[spot] = pos;
					fill++;
					r.status = sdib_pkg::ST_INSERTED;
					r.placed_at = 9'(spot);
					n_inserted++;
				end
			end else if (act == sdib_pkg::ACT_CLEAR) begin
				fill = 0;
				r.status = sdib_pkg::ST_CLEARED;
				n_cleared++;
			end else begin
				// read and spare action behave the same
				if (ridx < fill) begin
					r.status = sdib_pkg::ST_READ_OK;
					r.entry_key = key_table[ridx];
					r.entry_position = pos_table[ridx];
					n_read_ok++;
				end else begin
					r.status = sdib_pkg::ST_READ_OOR;
					n_read_oor++;
				end
			end
			r.entry_count = 10'(fill);
			awaited.push_back(r);
		endfunction

		function void compare_field(input string name, input logic [31:0] want,
				input logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		// compare one result word against the oldest expectation
		function void check_result(input logic [2:0] st, input logic [8:0] placed,
				input logic [9:0] cnt, input logic [31:0] key, input logic [9:0] pos);
			index_result_t exp;
			if (awaited.size() == 0) begin
				$display("%0t: result word with nothing expected, status %0h", $time, st);
				errors++;
				return;
			end
			exp = awaited.pop_front();
			n_checked++;
			compare_field("status", exp.status, st);
			compare_field("placed_at", exp.placed_at, placed);
			compare_field("entry_count", exp.entry_count, cnt);
			compare_field("entry_key", exp.entry_key, key);
			compare_field("entry_position", exp.entry_position, pos);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [3:0]  cfg_wdata = 4'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;  // record_key, block_ordinal, slot_in_block, read_index
	logic [1:0]  s_tuser = sdib_pkg::ACT_INSERT;  // action
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;  // placed_at, entry_count, entry_key, entry_position
	logic [2:0]  m_tuser;  // status

	dense_index_tracker tracker;

	sorted_dense_index_builder #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.BLOCK_COUNT(BLOCK_COUNT)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// watch both handshakes at the edge, values seen here are the pre-edge ones
	always @(posedge clk) begin
		if (tracker != null) begin
			if (s_tvalid && s_tready)
				tracker.note_word(s_tuser, s_tdata[31:0], s_tdata[38:32], s_tdata[41:39],
					s_tdata[50:42]);
			if (m_tvalid && m_tready)
				tracker.check_result(m_tuser, m_tdata[8:0], m_tdata[18:9], m_tdata[50:19],
					m_tdata[60:51]);
		end
	end

	// receiver: switches between open, choppy and long-stall patterns
	int rx_cycle = 0;
	int rx_mode = RX_OPEN;
	int stall_left = 0;
	always @(posedge clk) begin
		rx_cycle++;
		if (rx_cycle % 256 == 0)
			rx_mode = $urandom_range(RX_OPEN, RX_BURSTY);
		case (rx_mode)
			RX_OPEN: begin
				m_tready <= 1'b1;
			end
			RX_CHOPPY: begin
				m_tready <= ($urandom_range(0, 2) != 0);
			end
			default: begin
				if (stall_left > 0) begin
					stall_left--;
					m_tready <= 1'b0;
				end else if ($urandom_range(0, 15) == 0) begin
					stall_left = $urandom_range(1, 12);
					m_tready <= 1'b0;
				end else begin
					m_tready <= 1'b1;
				end
			end
		endcase
	end

	// present one word and hold it until the block takes it
	task automatic send_word(input logic [1:0] act, input logic [31:0] key,
			input logic [6:0] ordinal, input logic [2:0] slot, input logic [8:0] ridx);
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {5'd0, ridx, slot, ordinal, key};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// stop sending until every owed result has come back
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.awaited.size() != 0)
			@(posedge clk);
	endtask

	// new blocking factor, only with the block idle
	task automatic write_blocking(input logic [3:0] value);
		wait_for_results();
		repeat (6) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_blocking(value);
	endtask

	// bursts of random words with random gaps, reads mostly inside the table
	task automatic random_phase(input int items, input int key_span, input int insert_pct,
			input int clear_pct);
		int          sent, burst, pick, cnt;
		logic [1:0]  act;
		logic [31:0] key;
		logic [8:0]  ridx;
		sent = 0;
		while (sent < items) begin
			burst = $urandom_range(1, 24);
			for (int b = 0; b < burst && sent < items; b++) begin
				pick = $urandom_range(0, 99);
				cnt = tracker.fill;
				if (pick < clear_pct)
					act = sdib_pkg::ACT_CLEAR;
				else if (pick < clear_pct + insert_pct)
					act = sdib_pkg::ACT_INSERT;
				else
					act = ($urandom_range(0, 7) == 0) ? sdib_pkg::ACT_SPARE : sdib_pkg::ACT_READ;
				// narrow key span gives lots of equal keys
				if (key_span == 0)
					key = $urandom();
				else
					key = $urandom_range(0, key_span) - key_span / 2;
				case ($urandom_range(0, 31))
					0: key = 32'h8000_0000;
					1: key = 32'h7fff_ffff;
					default: ;
				endcase
				ridx = $urandom_range(0, 511);
				if (cnt > 0 && $urandom_range(0, 3) != 0)
					ridx = $urandom_range(0, cnt - 1);
				send_word(act, key, $urandom_range(0, 127), $urandom_range(0, 7), ridx);
				sent++;
			end
			// sometimes drain fully, often idle a while, otherwise run straight on
			if ($urandom_range(0, 39) == 0) begin
				wait_for_results();
			end else if ($urandom_range(0, 2) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	endtask

	initial begin
		tracker = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed words at the reset blocking factor
		send_word(sdib_pkg::ACT_READ, 32'h1234_5678, 7'd9, 3'd3, 9'd0);      // read on empty
		send_word(sdib_pkg::ACT_SPARE, 32'hffff_ffff, 7'd127, 3'd7, 9'd511); // spare, empty
		send_word(sdib_pkg::ACT_INSERT, 32'h0000_0000, 7'd0, 3'd0, 9'd0);
		send_word(sdib_pkg::ACT_INSERT, 32'h7fff_ffff, 7'd127, 3'd7, 9'd511); // largest key
		send_word(sdib_pkg::ACT_INSERT, 32'h8000_0000, 7'd3, 3'd1, 9'd0);    // smallest key
		send_word(sdib_pkg::ACT_INSERT, 32'hffff_ffff, 7'd64, 3'd4, 9'd256);
		send_word(sdib_pkg::ACT_INSERT, 32'h0000_0000, 7'd1, 3'd2, 9'd0);    // equal key first
		send_word(sdib_pkg::ACT_INSERT, 32'h7fff_ffff, 7'd2, 3'd5, 9'd0);    // slot past factor
		send_word(sdib_pkg::ACT_INSERT, 32'h0000_0001, 7'd10, 3'd7, 9'd0);
		send_word(sdib_pkg::ACT_READ, 32'h0, 7'd0, 3'd0, 9'd0);
		send_word(sdib_pkg::ACT_READ, 32'h0, 7'd0, 3'd0, 9'd1);
		send_word(sdib_pkg::ACT_READ, 32'h0, 7'd0, 3'd0, 9'd2);
		send_word(sdib_pkg::ACT_SPARE, 32'h0, 7'd0, 3'd0, 9'd3);
		send_word(sdib_pkg::ACT_READ, 32'h0, 7'd0, 3'd0, 9'd4);
		send_word(sdib_pkg::ACT_READ, 32'h0, 7'd0, 3'd0, 9'd5);
		send_word(sdib_pkg::ACT_READ, 32'h0, 7'd0, 3'd0, 9'd6);
		send_word(sdib_pkg::ACT_READ, 32'h0, 7'd0, 3'd0, 9'd7);              // one past count
		send_word(sdib_pkg::ACT_READ, 32'h0, 7'd0, 3'd0, 9'd511);
		send_word(sdib_pkg::ACT_CLEAR, 32'hdead_beef, 7'd85, 3'd6, 9'd341);
		send_word(sdib_pkg::ACT_READ, 32'h0, 7'd0, 3'd0, 9'd0);              // stale entry hidden
		send_word(sdib_pkg::ACT_INSERT, 32'h5555_5555, 7'h55, 3'd2, 9'h0aa);
		send_word(sdib_pkg::ACT_INSERT, 32'haaaa_aaaa, 7'h2a, 3'd5, 9'h155);
		send_word(sdib_pkg::ACT_SPARE, 32'h0, 7'd0, 3'd0, 9'd1);
		send_word(sdib_pkg::ACT_CLEAR, 32'h0, 7'd0, 3'd0, 9'd0);

		// many duplicates, factor of one
		write_blocking(4'd1);
		random_phase(320, 40, 55, 3);

		// wide keys, largest legal factor
		write_blocking(4'd8);
		random_phase(320, 0, 60, 2);

		// factor zero, fill the table until inserts are dropped
		write_blocking(4'd0);
		send_word(sdib_pkg::ACT_CLEAR, 32'h0, 7'd0, 3'd0, 9'd0);
		random_phase(580, 0, 100, 0);
		random_phase(150, 1000, 40, 0);

		// largest field value, positions wrap
		write_blocking(4'd15);
		random_phase(300, 1000, 60, 2);

		wait_for_results();
		repeat (12) @(posedge clk);
		$display("covered %0d inserts, %0d dropped on a full table, %0d reads in range,",
			tracker.n_inserted, tracker.n_dropped, tracker.n_read_ok);
		$display("%0d reads past the count, %0d clears, %0d result words checked",
			tracker.n_read_oor, tracker.n_cleared, tracker.n_checked);
		if (tracker.errors == 0 && tracker.awaited.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#4_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
